// ===== sv/ccc_pkg.sv =====
// calendar clock counter: shared types, constants and calendar tables
// no dependencies; imported by ccc_year_split, calendar_clock_counter_unit and both testbench files
`default_nettype none

package ccc_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int WDAY_W   = 3;
    localparam int YDAY_W   = 9;
    localparam int CENT_W   = 7;
    localparam int ZSUM_W   = 10;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    // floor(y / 100) = (y * 5243) >> 19 for y below 16384
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;
    localparam int PROD_W       = 27;

    localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST   = 5'd1;
    localparam logic [HOUR_W-1:0]  HOUR_LAST   = 5'd23;
    localparam logic [MIN_W-1:0]   MIN_LAST    = 6'd59;
    localparam logic [SEC_W-1:0]   SEC_LAST    = 6'd59;
    localparam logic [WDAY_W-1:0]  WDAY_SAT    = 3'd6;
    localparam logic [WDAY_W-1:0]  WDAY_SUN    = 3'd0;
    localparam logic [YDAY_W-1:0]  YDAY_FIRST  = 9'd1;
    localparam logic [CENT_W-1:0]  CENT_LAST   = 7'd99;
    localparam logic [CENT_W-1:0]  YOC_LAST    = 7'd99;
    localparam logic [ZSUM_W-1:0]  ZELLER_BIAS = 10'd209;

    typedef enum logic {
        ACT_TICK = 1'b0,
        ACT_SET  = 1'b1
    } action_t;

    // first member is the most significant: year lands in the lowest bits
    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } set_fields_t;

    // year split into century and year of century, plus the zeller year
    typedef struct packed {
        logic [CENT_W-1:0] cent;
        logic [CENT_W-1:0] yoc;
        logic [CENT_W-1:0] zcent;
        logic [CENT_W-1:0] zyoc;
    } year_split_t;

    typedef struct packed {
        action_t     action;
        set_fields_t f;
        year_split_t split;
    } a_item_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [CENT_W-1:0]  cent;
        logic [CENT_W-1:0]  yoc;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [WDAY_W-1:0]  wday;
        logic [YDAY_W-1:0]  yday;
    } cal_state_t;

    typedef struct packed {
        logic               rejected;
        logic [YDAY_W-1:0]  yday;
        logic [WDAY_W-1:0]  wday;
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } result_t;

    localparam cal_state_t CAL_RESET = '{
        year:   14'd2000,
        cent:   7'd20,
        yoc:    7'd0,
        month:  4'd1,
        day:    5'd1,
        hour:   5'd0,
        minute: 6'd0,
        second: 6'd0,
        wday:   3'd6,
        yday:   9'd1
    };

    function automatic logic is_leap(input logic [CENT_W-1:0] cent,
                                     input logic [CENT_W-1:0] yoc);
        return (yoc[1:0] == 2'd0) && ((yoc != '0) || (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd2:                      d = 5'd28 + {4'd0, leap};
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

    function automatic logic [YDAY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [YDAY_W-1:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // floor(13 * (m' + 1) / 5) with january and february as months 13 and 14
    function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] m);
        logic [5:0] t;
        unique case (m)
            4'd1:    t = 6'd36;
            4'd2:    t = 6'd39;
            4'd3:    t = 6'd10;
            4'd4:    t = 6'd13;
            4'd5:    t = 6'd15;
            4'd6:    t = 6'd18;
            4'd7:    t = 6'd20;
            4'd8:    t = 6'd23;
            4'd9:    t = 6'd26;
            4'd10:   t = 6'd28;
            4'd11:   t = 6'd31;
            4'd12:   t = 6'd33;
            default: t = 6'd0;
        endcase
        return t;
    endfunction

    // 8 and 64 and 512 are all 1 mod 7, so octal digits fold
    function automatic logic [WDAY_W-1:0] mod7(input logic [ZSUM_W-1:0] x);
        logic [4:0] s1;
        logic [3:0] s2;
        s1 = {4'd0, x[9]} + {2'd0, x[8:6]} + {2'd0, x[5:3]} + {2'd0, x[2:0]};
        s2 = {2'd0, s1[4:3]} + {1'b0, s1[2:0]};
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/ccc_year_split.sv =====
// calendar clock counter: splits a set year into century and year of century
// for both the year itself and the zeller year; uses ccc_pkg
`default_nettype none

module ccc_year_split (
    input  ccc_pkg::set_fields_t f,
    output ccc_pkg::year_split_t split
);
    import ccc_pkg::*;

    logic [YEAR_W-1:0] zyear;
    logic [7:0]        cent_full;
    logic [7:0]        zcent_full;

    function automatic logic [7:0] div100(input logic [YEAR_W-1:0] y);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(y) * PROD_W'(DIV100_MUL);
        return prod[PROD_W-1:DIV100_SHIFT];
    endfunction

    function automatic logic [CENT_W-1:0] rem100(input logic [YEAR_W-1:0] y,
                                                 input logic [7:0] c);
        logic [YEAR_W-1:0] r;
        r = y - YEAR_W'(YEAR_W'(c) * 14'd100);
        return r[CENT_W-1:0];
    endfunction

    // january and february belong to the previous year
    assign zyear      = (f.month <= MONTH_FEB) ? f.year - 14'd1 : f.year;
    assign cent_full  = div100(f.year);
    assign zcent_full = div100(zyear);

    assign split.cent  = cent_full[CENT_W-1:0];
    assign split.yoc   = rem100(f.year, cent_full);
    assign split.zcent = zcent_full[CENT_W-1:0];
    assign split.zyoc  = rem100(zyear, zcent_full);

endmodule

`default_nettype wire

// ===== sv/calendar_clock_counter_unit.sv =====
// calendar clock counter: top level with input stage, calendar state and result register
// uses ccc_pkg and ccc_year_split
// flow: a transaction is held in the input register, then its result is registered into the result register on m_tdata
// throughput: one transaction per cycle while m_tready does not stall; the calendar state is registered with the result
// stall: s_tready follows m_tready through the input and result registers
// reset: pipeline empty, time 2000-01-01 00:00:00, saturday, day of year 1
`default_nettype none

module calendar_clock_counter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // year, month, day, hour, minute, second
    input  logic [ccc_pkg::S_DATA_W-1:0]  s_tdata,
    // action (0 tick, 1 set)
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // year, month, day, hour, minute, second, week day, year day, set rejected, zero pad
    output logic [ccc_pkg::M_DATA_W-1:0]  m_tdata
);
    import ccc_pkg::*;

    set_fields_t s_fields;
    year_split_t s_split;

    logic       a_vld_reg, a_vld_next;
    a_item_t    a_reg, a_next;
    logic       m_vld_reg, m_vld_next;
    result_t    out_reg, out_next;
    cal_state_t cal_reg, cal_next;
    cal_state_t tick_st, set_st;

    logic       b_adv;
    logic       cur_leap, set_leap, set_ok;
    logic [ZSUM_W-1:0] zsum;

    assign s_fields = set_fields_t'(s_tdata);

    ccc_year_split u_split (
        .f     (s_fields),
        .split (s_split)
    );

    assign b_adv    = a_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !a_vld_reg || b_adv;
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {(M_DATA_W - $bits(result_t))'(0), out_reg};

    // input stage
    always_comb begin
        a_vld_next = a_vld_reg;
        a_next     = a_reg;
        if (s_tvalid && s_tready) begin
            a_vld_next    = 1'b1;
            a_next.action = action_t'(s_tuser);
            a_next.f      = s_fields;
            a_next.split  = s_split;
        end else if (b_adv) begin
            a_vld_next = 1'b0;
        end
    end

    // one second forward
    assign cur_leap = is_leap(cal_reg.cent, cal_reg.yoc);

    always_comb begin
        tick_st = cal_reg;
        if (cal_reg.second != SEC_LAST) begin
            tick_st.second = cal_reg.second + 6'd1;
        end else begin
            tick_st.second = '0;
            if (cal_reg.minute != MIN_LAST) begin
                tick_st.minute = cal_reg.minute + 6'd1;
            end else begin
                tick_st.minute = '0;
                if (cal_reg.hour != HOUR_LAST) begin
                    tick_st.hour = cal_reg.hour + 5'd1;
                end else begin
                    tick_st.hour = '0;
                    tick_st.wday = (cal_reg.wday >= WDAY_SAT) ? WDAY_SUN
                                                              : cal_reg.wday + 3'd1;
                    tick_st.yday = cal_reg.yday + 9'd1;
                    if (cal_reg.day < month_days(cal_reg.month, cur_leap)) begin
                        tick_st.day = cal_reg.day + 5'd1;
                    end else begin
                        tick_st.day = DAY_FIRST;
                        if (cal_reg.month < MONTH_DEC) begin
                            tick_st.month = cal_reg.month + 4'd1;
                        end else begin
                            tick_st.month = MONTH_JAN;
                            tick_st.yday  = YDAY_FIRST;
                            if (cal_reg.year >= YEAR_MAX) begin
                                tick_st.year = YEAR_MIN;
                                tick_st.cent = '0;
                                tick_st.yoc  = 7'd1;
                            end else begin
                                tick_st.year = cal_reg.year + 14'd1;
                                if (cal_reg.yoc == YOC_LAST) begin
                                    tick_st.yoc  = '0;
                                    tick_st.cent = cal_reg.cent + 7'd1;
                                end else begin
                                    tick_st.yoc = cal_reg.yoc + 7'd1;
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    // load date and time with range check, weekday and day of year
    assign set_leap = is_leap(a_reg.split.cent, a_reg.split.yoc);
    assign set_ok   = (a_reg.f.year >= YEAR_MIN) && (a_reg.f.year <= YEAR_MAX)
                   && (a_reg.f.month >= MONTH_JAN) && (a_reg.f.month <= MONTH_DEC)
                   && (a_reg.f.day >= DAY_FIRST)
                   && (a_reg.f.day <= month_days(a_reg.f.month, set_leap))
                   && (a_reg.f.hour <= HOUR_LAST) && (a_reg.f.minute <= MIN_LAST)
                   && (a_reg.f.second <= SEC_LAST);

    assign zsum = ZSUM_W'(a_reg.split.zcent[CENT_W-1:2]) + ZSUM_W'(a_reg.split.zyoc)
                + ZSUM_W'(a_reg.split.zyoc[CENT_W-1:2]) + ZSUM_W'(zeller_month(a_reg.f.month))
                + ZSUM_W'(a_reg.f.day) + ZELLER_BIAS - ZSUM_W'({a_reg.split.zcent, 1'b0});

    always_comb begin
        set_st        = cal_reg;
        set_st.year   = a_reg.f.year;
        set_st.cent   = a_reg.split.cent;
        set_st.yoc    = a_reg.split.yoc;
        set_st.month  = a_reg.f.month;
        set_st.day    = a_reg.f.day;
        set_st.hour   = a_reg.f.hour;
        set_st.minute = a_reg.f.minute;
        set_st.second = a_reg.f.second;
        set_st.wday   = mod7(zsum);
        set_st.yday   = days_before(a_reg.f.month) + YDAY_W'(a_reg.f.day)
                      + YDAY_W'((a_reg.f.month > MONTH_FEB) && set_leap);
    end

    // state and result register
    always_comb begin
        cal_next          = cal_reg;
        m_vld_next        = m_vld_reg;
        out_next          = out_reg;
        out_next.rejected = 1'b0;
        if (b_adv) begin
            unique case (a_reg.action)
                ACT_TICK: cal_next = tick_st;
                ACT_SET: begin
                    if (set_ok) begin
                        cal_next = set_st;
                    end else begin
                        out_next.rejected = 1'b1;
                    end
                end
                default: cal_next = cal_reg;
            endcase
            m_vld_next = 1'b1;
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
        if (!b_adv) begin
            out_next.rejected = out_reg.rejected;
        end
        out_next.year   = cal_next.year;
        out_next.month  = cal_next.month;
        out_next.day    = cal_next.day;
        out_next.hour   = cal_next.hour;
        out_next.minute = cal_next.minute;
        out_next.second = cal_next.second;
        out_next.wday   = cal_next.wday;
        out_next.yday   = cal_next.yday;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            cal_reg   <= CAL_RESET;
        end else begin
            a_vld_reg <= a_vld_next;
            m_vld_reg <= m_vld_next;
            cal_reg   <= cal_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        out_reg <= out_next;
    end

`ifndef ASSERT_OFF
    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cal_reg.second <= SEC_LAST) && (cal_reg.minute <= MIN_LAST)
        && (cal_reg.hour <= HOUR_LAST))
        else $error("time of day out of range");

    a_year_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (cal_reg.yoc <= YOC_LAST) && (cal_reg.cent <= CENT_LAST)
        && (cal_reg.year == YEAR_W'(cal_reg.cent) * 14'd100 + YEAR_W'(cal_reg.yoc)))
        else $error("century split disagrees with year");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cal_reg.day >= DAY_FIRST) && (cal_reg.day <= month_days(cal_reg.month, cur_leap))
        && (cal_reg.month >= MONTH_JAN) && (cal_reg.month <= MONTH_DEC))
        else $error("date out of range");

    a_tick_not_rejected: assert property (@(posedge aclk) disable iff (!aresetn)
        b_adv && (a_reg.action == ACT_TICK) |=> !out_reg.rejected)
        else $error("tick transaction flagged as rejected set");

    a_reject_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        b_adv && (a_reg.action == ACT_SET) && !set_ok |=> $stable(cal_reg))
        else $error("rejected set changed the time");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/calendar_time_checker.sv =====
// calendar clock counter checker: watches both stream channels, predicts the time after each
// transaction and compares every result field; depends on ccc_pkg for widths and packed types
`default_nettype none

module calendar_time_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [ccc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [ccc_pkg::M_DATA_W-1:0] m_tdata,
    output int                           fail_count,
    output int                           pending,
    output int                           set_count,
    output int                           reject_count,
    output int                           tick_count,
    output int                           midnight_count
);
    import ccc_pkg::*;

    result_t clock_now;
    result_t expected_times [$];
    int      result_count;

    function automatic bit leap_year(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int days_in(input int y, input int m);
        case (m)
            2:            return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:  return 30;
            default:      return 31;
        endcase
    endfunction

    function automatic int year_day(input int y, input int m, input int d);
        int n;
        n = d;
        for (int k = 1; k < m; k++) begin
            n += days_in(y, k);
        end
        return n;
    endfunction

    // january and february count as months 13 and 14 of the previous year
    function automatic int zeller_weekday(input int y, input int m, input int d);
        int c;
        int yy;
        int w;
        if (m <= 2) begin
            y = y - 1;
            m = m + 12;
        end
        c = y / 100;
        yy = y % 100;
        w = c / 4 + yy + yy / 4 + (13 * (m + 1)) / 5 + d + 210 - 1 - 2 * c;
        return w % 7;
    endfunction

    function automatic bit set_is_valid(input set_fields_t f);
        if (f.year < 1 || f.year > 9999 || f.month < 1 || f.month > 12) begin
            return 1'b0;
        end
        if (f.hour > 23 || f.minute > 59 || f.second > 59) begin
            return 1'b0;
        end
        return (f.day >= 1) && (int'(f.day) <= days_in(f.year, f.month));
    endfunction

    task automatic advance_clock();
        if (clock_now.second < 59) begin
            clock_now.second += 1;
            return;
        end
        clock_now.second = '0;
        if (clock_now.minute < 59) begin
            clock_now.minute += 1;
            return;
        end
        clock_now.minute = '0;
        if (clock_now.hour < 23) begin
            clock_now.hour += 1;
            return;
        end
        clock_now.hour = '0;
        midnight_count++;
        clock_now.wday = (clock_now.wday >= 6) ? 3'd0 : clock_now.wday + 3'd1;
        if (int'(clock_now.day) < days_in(clock_now.year, clock_now.month)) begin
            clock_now.day += 1;
        end else begin
            clock_now.day = 5'd1;
            if (clock_now.month < 12) begin
                clock_now.month += 1;
            end else begin
                clock_now.month = 4'd1;
                clock_now.year = (clock_now.year >= 9999) ? 14'd1 : clock_now.year + 14'd1;
            end
        end
        clock_now.yday = 9'(year_day(clock_now.year, clock_now.month, clock_now.day));
    endtask

    task automatic apply_transaction(input action_t act, input set_fields_t f,
                                     output result_t want);
        bit refused;
        refused = 1'b0;
        if (act == ACT_SET) begin
            set_count++;
            if (set_is_valid(f)) begin
                clock_now.year   = f.year;
                clock_now.month  = f.month;
                clock_now.day    = f.day;
                clock_now.hour   = f.hour;
                clock_now.minute = f.minute;
                clock_now.second = f.second;
                clock_now.wday   = 3'(zeller_weekday(f.year, f.month, f.day));
                clock_now.yday   = 9'(year_day(f.year, f.month, f.day));
            end else begin
                refused = 1'b1;
                reject_count++;
            end
        end else begin
            tick_count++;
            advance_clock();
        end
        want = clock_now;
        want.rejected = refused;
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < 40) begin
            $display("mismatch on result %0d: %s", result_count, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input int got_v, input int want_v);
        if (got_v != want_v) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got_v, want_v));
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            clock_now = '0;
            clock_now.year  = 14'd2000;
            clock_now.month = 4'd1;
            clock_now.day   = 5'd1;
            clock_now.wday  = 3'd6;
            clock_now.yday  = 9'd1;
            expected_times.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                apply_transaction(action_t'(s_tuser), set_fields_t'(s_tdata), want);
                expected_times.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                result_count++;
                got = m_tdata[$bits(result_t)-1:0];
                if (expected_times.size() == 0) begin
                    report_mismatch("transaction with no expected time waiting");
                end else begin
                    want = expected_times.pop_front();
                    check_field("year", got.year, want.year);
                    check_field("month", got.month, want.month);
                    check_field("day", got.day, want.day);
                    check_field("hour", got.hour, want.hour);
                    check_field("minute", got.minute, want.minute);
                    check_field("second", got.second, want.second);
                    check_field("week day", got.wday, want.wday);
                    check_field("year day", got.yday, want.yday);
                    check_field("set rejected", got.rejected, want.rejected);
                    check_field("pad", int'(m_tdata[M_DATA_W-1:$bits(result_t)]), 0);
                end
            end
        end
        pending <= expected_times.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/calendar_clock_counter_unit_test.sv =====
// calendar clock counter testbench top: clock, reset, tick and set stimulus, receiver stalls
// depends on ccc_pkg, calendar_clock_counter_unit and calendar_time_checker
`default_nettype none

module calendar_clock_counter_unit_test;
    import ccc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 800;
    localparam int LONG_HOLD   = 400;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int   fail_count;
    int   pending;
    int   set_count;
    int   reject_count;
    int   tick_count;
    int   midnight_count;
    int   tx_idle_pct = 36;
    int   rx_idle_pct = 70;
    logic long_hold_req = 1'b0;
    logic long_hold_done = 1'b0;
    int   hold_left = 0;
    int   sent = 0;
    int   cycle_count = 0;

    calendar_clock_counter_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    calendar_time_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .fail_count     (fail_count),
        .pending        (pending),
        .set_count      (set_count),
        .reject_count   (reject_count),
        .tick_count     (tick_count),
        .midnight_count (midnight_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic drive_item(input action_t act, input set_fields_t f);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= f;
        s_tuser <= act;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sent++;
    endtask

    task automatic send_set(input int y, mo, d, h, mi, s);
        set_fields_t f;
        f.year   = 14'(y);
        f.month  = 4'(mo);
        f.day    = 5'(d);
        f.hour   = 5'(h);
        f.minute = 6'(mi);
        f.second = 6'(s);
        drive_item(ACT_SET, f);
    endtask

    // set fields ride along with a tick and must be ignored
    task automatic send_tick();
        drive_item(ACT_TICK, set_fields_t'({8'($urandom), 32'($urandom)}));
    endtask

    initial begin
        int          y;
        int          mo;
        int          r;
        int          phase;
        set_fields_t f;

        phase = 1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_tick();
        send_set(9999, 12, 31, 23, 59, 59);
        send_tick();
        send_set(1, 1, 1, 0, 0, 0);
        send_set(1, 2, 28, 23, 59, 59);
        send_tick();
        send_set(2000, 2, 29, 23, 59, 59);
        send_tick();
        send_set(1900, 2, 29, 0, 0, 0);
        send_set(2004, 2, 29, 12, 34, 56);
        send_set(2023, 12, 31, 23, 59, 59);
        send_tick();
        send_set(2024, 4, 31, 0, 0, 0);
        send_set(2024, 4, 30, 23, 59, 59);
        send_tick();
        send_set(0, 6, 1, 0, 0, 0);
        send_set(16383, 6, 1, 0, 0, 0);
        send_set(2024, 0, 1, 0, 0, 0);
        send_set(2024, 15, 1, 0, 0, 0);
        send_set(2024, 1, 0, 0, 0, 0);
        send_set(2024, 1, 31, 31, 0, 0);
        send_set(2024, 1, 31, 0, 63, 0);
        send_set(2024, 1, 31, 0, 0, 63);
        send_set(2024, 1, 31, 23, 59, 59);
        send_tick();

        while (sent < ITEM_TARGET) begin
            if (phase == 1 && sent >= ITEM_TARGET / 3) begin
                phase = 2;
                tx_idle_pct = 70;
                rx_idle_pct <= 36;
            end else if (phase == 2 && sent >= 2 * ITEM_TARGET / 3) begin
                phase = 3;
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
                long_hold_req <= 1'b1;
            end

            r = $urandom_range(0, 99);
            if (r < 65) begin
                // set a time that is often just before midnight, then send ticks that may carry across it
                case ($urandom_range(0, 9))
                    0:       y = 9999;
                    1:       y = 1;
                    2:       y = 2000;
                    3:       y = 1900;
                    4:       y = 2100;
                    5:       y = 1600;
                    6:       y = 4 * $urandom_range(1, 2499);
                    default: y = $urandom_range(1, 9999);
                endcase
                mo = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
                send_set(y, mo,
                         $urandom_range(0, 1) ? $urandom_range(28, 31) : $urandom_range(1, 28),
                         ($urandom_range(0, 3) != 0) ? 23 : $urandom_range(0, 23),
                         ($urandom_range(0, 3) != 0) ? 59 : $urandom_range(0, 59),
                         ($urandom_range(0, 3) != 0) ? $urandom_range(50, 59)
                                                     : $urandom_range(0, 59));
                repeat ($urandom_range(1, 12)) send_tick();
            end else if (r < 80) begin
                // plausible set with one field pushed out of range (a day of 29 to 31 may still be valid)
                f.year   = 14'($urandom_range(1, 9999));
                f.month  = 4'($urandom_range(1, 12));
                f.day    = 5'($urandom_range(1, 28));
                f.hour   = 5'($urandom_range(0, 23));
                f.minute = 6'($urandom_range(0, 59));
                f.second = 6'($urandom_range(0, 59));
                case ($urandom_range(0, 5))
                    0:       f.year = $urandom_range(0, 1) ? 14'd0
                                                           : 14'($urandom_range(10000, 16383));
                    1:       f.month = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
                    2:       f.day = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(29, 31));
                    3:       f.hour = 5'($urandom_range(24, 31));
                    4:       f.minute = 6'($urandom_range(60, 63));
                    default: f.second = 6'($urandom_range(60, 63));
                endcase
                drive_item(ACT_SET, f);
                repeat ($urandom_range(1, 3)) send_tick();
            end else if (r < 95) begin
                drive_item(ACT_SET, set_fields_t'({8'($urandom), 32'($urandom)}));
                send_tick();
            end else begin
                repeat ($urandom_range(20, 90)) send_tick();
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);

        $display("covered %0d transactions: %0d sets (%0d refused) and %0d one-second ticks",
                 sent, set_count, reject_count, tick_count);
        $display("%0d midnight carries, through month ends, leap days and the year 9999 wrap",
                 midnight_count);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== calendar_clock_counter_unit.f =====
sv/ccc_pkg.sv
sv/ccc_year_split.sv
sv/calendar_clock_counter_unit.sv
tb/sv/calendar_time_checker.sv
tb/sv/calendar_clock_counter_unit_test.sv
